>>> design/pcrs_pkg.sv
package pcrs_pkg;

  localparam int unsigned CH_W            = 3;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned DEF_CHANNELS    = 8;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CH_CMP_W        = 9;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            in_range;
  } pcrs_tag_t;

endpackage

>>> design/pcrs_front.sv
module pcrs_front
  import pcrs_pkg::*;
#(
  parameter int unsigned CHANNELS    = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CH_W-1:0]               channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output pcrs_tag_t                     q_tag_o,
  output logic signed [SAMPLE_BITS-1:0] q_sample_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pcrs_tag_t                     tag_q [QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] smp_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]              rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          push;
  logic                          pop;
  pcrs_tag_t                     new_tag;

  assign in_stall_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    new_tag.channel  = channel_i;
    new_tag.in_range = (CH_CMP_W'(channel_i) < CH_CMP_W'(CHANNELS));
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      tag_q[wr_ptr_q] <= new_tag;
      smp_q[wr_ptr_q] <= sample_i;
    end
  end

  assign q_tag_o    = tag_q[rd_ptr_q];
  assign q_sample_o = smp_q[rd_ptr_q];

endmodule

>>> design/pcrs_div.sv
module pcrs_div
  import pcrs_pkg::*;
#(
  parameter int unsigned NUM_W = DEF_SAMPLE_BITS + COUNT_W,
  parameter int unsigned DEN_W = COUNT_W,
  parameter int unsigned Q_W   = DEF_SAMPLE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    done_o,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic [Q_W-1:0]          quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_ABS,
    D_RUN,
    D_FIN
  } div_state_e;

  div_state_e       state_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             done_q;
  logic [Q_W-1:0]   quot_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      quot_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            num_q   <= num_i;
            den_q   <= den_i;
            neg_q   <= num_i[NUM_W-1];
            state_q <= D_ABS;
          end
        end
        D_ABS: begin
          if (neg_q) begin
            num_q <= ~num_q + 1'b1;
          end
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= D_RUN;
        end
        D_RUN: begin
          rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          num_q <= {num_q[NUM_W-2:0], qbit};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          quot_q  <= neg_q ? (~num_q[Q_W-1:0] + 1'b1) : num_q[Q_W-1:0];
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> design/pcrs_back.sv
module pcrs_back
  import pcrs_pkg::*;
#(
  parameter int unsigned CHANNELS    = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  pcrs_tag_t                     q_tag_i,
  input  logic signed [SAMPLE_BITS-1:0] q_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CH_W-1:0]               channel_out_o,
  output logic signed [SAMPLE_BITS-1:0] mean_o,
  output logic [COUNT_W-1:0]            sample_count_o,
  output logic signed [SAMPLE_BITS-1:0] minimum_o,
  output logic signed [SAMPLE_BITS-1:0] maximum_o,
  output logic                          overflow_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + COUNT_W;
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } back_state_e;

  back_state_e                   state_q;
  logic signed [SUM_W-1:0]       sum_q [CHANNELS];
  logic [COUNT_W-1:0]            count_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] min_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] max_q [CHANNELS];

  logic [IDX_W-1:0]              idx;
  logic [CH_CMP_W-1:0]           ch_ext;
  logic signed [SUM_W-1:0]       rd_sum;
  logic [COUNT_W-1:0]            rd_count;
  logic signed [SAMPLE_BITS-1:0] rd_min;
  logic signed [SAMPLE_BITS-1:0] rd_max;
  logic                          ovf;
  logic                          pos;
  logic                          upd;
  logic signed [SUM_W-1:0]       upd_sum;
  logic [COUNT_W-1:0]            upd_count;
  logic signed [SAMPLE_BITS-1:0] upd_min;
  logic signed [SAMPLE_BITS-1:0] upd_max;

  logic                          div_start;
  logic                          div_done;
  logic [SAMPLE_BITS-1:0]        quot;

  logic                          out_valid_q;
  logic [CH_W-1:0]               ch_out_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic [COUNT_W-1:0]            cnt_out_q;
  logic signed [SAMPLE_BITS-1:0] min_out_q;
  logic signed [SAMPLE_BITS-1:0] max_out_q;
  logic                          ovf_out_q;

  assign ch_ext  = CH_CMP_W'(q_tag_i.channel);
  assign idx     = ch_ext[IDX_W-1:0];
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    rd_sum   = sum_q[idx];
    rd_count = count_q[idx];
    rd_min   = min_q[idx];
    rd_max   = max_q[idx];
    ovf      = (rd_count == '1);
    pos      = !q_sample_i[SAMPLE_BITS-1] && (q_sample_i != '0);
    upd      = q_pop_o && q_tag_i.in_range && !ovf;
    upd_sum   = rd_sum;
    upd_count = rd_count;
    upd_min   = rd_min;
    upd_max   = rd_max;
    if (!ovf) begin
      upd_sum   = rd_sum + {{COUNT_W{q_sample_i[SAMPLE_BITS-1]}}, q_sample_i};
      upd_count = rd_count + 1'b1;
      if (pos) begin
        if (rd_count == '0) begin
          upd_min = q_sample_i;
          upd_max = q_sample_i;
        end else begin
          if (q_sample_i > rd_max) begin
            upd_max = q_sample_i;
          end
          if (q_sample_i < rd_min) begin
            upd_min = q_sample_i;
          end
        end
      end
    end
    div_start = q_pop_o && q_tag_i.in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i]   <= '0;
        count_q[i] <= '0;
        min_q[i]   <= '0;
        max_q[i]   <= '0;
      end
    end else if (upd) begin
      sum_q[idx]   <= upd_sum;
      count_q[idx] <= upd_count;
      min_q[idx]   <= upd_min;
      max_q[idx]   <= upd_max;
    end
  end

  pcrs_div #(
    .NUM_W (SUM_W),
    .DEN_W (COUNT_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .done_o  (div_done),
    .num_i   (upd_sum),
    .den_i   (upd_count),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ch_out_q    <= '0;
      mean_q      <= '0;
      cnt_out_q   <= '0;
      min_out_q   <= '0;
      max_out_q   <= '0;
      ovf_out_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            ch_out_q <= q_tag_i.channel;
            if (q_tag_i.in_range) begin
              cnt_out_q <= upd_count;
              min_out_q <= upd_min;
              max_out_q <= upd_max;
              ovf_out_q <= ovf;
              state_q   <= ST_DIV;
            end else begin
              mean_q      <= '0;
              cnt_out_q   <= '0;
              min_out_q   <= '0;
              max_out_q   <= '0;
              ovf_out_q   <= 1'b0;
              out_valid_q <= 1'b1;
              state_q     <= ST_HOLD;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_q      <= quot;
            out_valid_q <= 1'b1;
            state_q     <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_out_o  = ch_out_q;
  assign mean_o         = mean_q;
  assign sample_count_o = cnt_out_q;
  assign minimum_o      = min_out_q;
  assign maximum_o      = max_out_q;
  assign overflow_o     = ovf_out_q;

endmodule

>>> design/per_channel_running_stats.sv
// This block keeps a running sum, a sample count, a minimum and a maximum for each channel.
// The input channel carries one tagged sample per transaction on channel_i and sample_i.
// The output channel returns one transaction per input with the updated mean, count,
// minimum, maximum and an overflow flag that marks a dropped sample.
// A transaction moves when valid is high and stall is low.
// A two-entry queue takes input transactions while the back end is busy.
// The back end works on one transaction at a time, and the mean comes from a
// restoring divider that produces one quotient bit per cycle over the 48-bit sum.
// The back end takes no new transaction until the previous result has left the output.
// A channel number outside the configured range returns zeros.
// While the output is stalled, the result is held and the queue keeps filling.
// Reset clears every channel's statistics and empties the queue.
module per_channel_running_stats
  import pcrs_pkg::*;
#(
  parameter int unsigned CHANNELS    = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CH_W-1:0]               channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CH_W-1:0]               channel_out_o,
  output logic signed [SAMPLE_BITS-1:0] mean_o,
  output logic [COUNT_W-1:0]            sample_count_o,
  output logic signed [SAMPLE_BITS-1:0] minimum_o,
  output logic signed [SAMPLE_BITS-1:0] maximum_o,
  output logic                          overflow_o
);

  logic                          q_valid;
  logic                          q_pop;
  pcrs_tag_t                     q_tag;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  pcrs_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_tag_o    (q_tag),
    .q_sample_o (q_sample)
  );

  pcrs_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_tag_i        (q_tag),
    .q_sample_i     (q_sample),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_out_o  (channel_out_o),
    .mean_o         (mean_o),
    .sample_count_o (sample_count_o),
    .minimum_o      (minimum_o),
    .maximum_o      (maximum_o),
    .overflow_o     (overflow_o)
  );

`ifndef SYNTHESIS
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> sample_count_o == '1)
    else $error("overflow reported without a saturated count");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_count_o == '0) |->
      (mean_o == '0) && (minimum_o == '0) && (maximum_o == '0) && !overflow_o)
    else $error("empty result carries nonzero statistics");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> minimum_o <= maximum_o)
    else $error("minimum exceeds maximum");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

>>> tb/sv/per_channel_running_stats_tb.sv
module per_channel_running_stats_tb;
  import pcrs_pkg::*;

  localparam int CHANNELS    = DEF_CHANNELS;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 80;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    logic [CH_W-1:0]    channel;
    sample_t            mean;
    logic [COUNT_W-1:0] sample_count;
    sample_t            minimum;
    sample_t            maximum;
    logic               overflow;
  } stats_result_t;

  class stats_scoreboard;
    bit signed [SAMPLE_BITS+31:0] sum_by_ch[CHANNELS];
    bit [COUNT_W-1:0]             count_by_ch[CHANNELS];
    bit signed [SAMPLE_BITS-1:0]  min_by_ch[CHANNELS];
    bit signed [SAMPLE_BITS-1:0]  max_by_ch[CHANNELS];
    stats_result_t                expected_q[$];
    int                           mismatches = 0;

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [CH_W-1:0] ch, sample_t s);
      stats_result_t r;
      longint quotient;
      r.channel      = ch;
      r.mean         = '0;
      r.sample_count = '0;
      r.minimum      = '0;
      r.maximum      = '0;
      r.overflow     = 1'b0;
      if (ch < CHANNELS) begin
        if (count_by_ch[ch] == '1) begin
          r.overflow = 1'b1;
        end else begin
          sum_by_ch[ch]   = sum_by_ch[ch] + s;
          count_by_ch[ch] = count_by_ch[ch] + 1;
          if (s > 0) begin
            if (count_by_ch[ch] == 1) begin
              min_by_ch[ch] = s;
              max_by_ch[ch] = s;
            end else begin
              if (s > max_by_ch[ch]) max_by_ch[ch] = s;
              if (s < min_by_ch[ch]) min_by_ch[ch] = s;
            end
          end
        end
        if (count_by_ch[ch] != 0) begin
          quotient = longint'(sum_by_ch[ch]) / longint'(count_by_ch[ch]);
          r.mean   = quotient[SAMPLE_BITS-1:0];
        end
        r.sample_count = count_by_ch[ch];
        r.minimum      = min_by_ch[ch];
        r.maximum      = max_by_ch[ch];
      end
      expected_q.push_back(r);
    endfunction

    task check_result(logic [CH_W-1:0] ch, sample_t mean, logic [COUNT_W-1:0] cnt,
                      sample_t mn, sample_t mx, logic ovf);
      stats_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction on channel %0d", ch));
      end else begin
        e = expected_q.pop_front();
        if (ch !== e.channel)
          report($sformatf("channel_out got %0d want %0d", ch, e.channel));
        if (mean !== e.mean)
          report($sformatf("ch %0d mean got %0d want %0d", e.channel, mean, e.mean));
        if (cnt !== e.sample_count)
          report($sformatf("ch %0d sample_count got %0d want %0d", e.channel, cnt,
                           e.sample_count));
        if (mn !== e.minimum)
          report($sformatf("ch %0d minimum got %0d want %0d", e.channel, mn, e.minimum));
        if (mx !== e.maximum)
          report($sformatf("ch %0d maximum got %0d want %0d", e.channel, mx, e.maximum));
        if (ovf !== e.overflow)
          report($sformatf("ch %0d overflow got %0b want %0b", e.channel, ovf,
                           e.overflow));
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [CH_W-1:0]    channel_i   = '0;
  sample_t            sample_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CH_W-1:0]    channel_out_o;
  sample_t            mean_o;
  logic [COUNT_W-1:0] sample_count_o;
  sample_t            minimum_o;
  sample_t            maximum_o;
  logic               overflow_o;

  stats_scoreboard sb = new();
  int idle_pct    = 0;
  int stall_pct   = 0;
  bit hold_pending = 1'b0;

  per_channel_running_stats #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_out_o  (channel_out_o),
    .mean_o         (mean_o),
    .sample_count_o (sample_count_o),
    .minimum_o      (minimum_o),
    .maximum_o      (maximum_o),
    .overflow_o     (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  // The receiver stalls at random; a requested hold-off keeps it stalled for a long stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(channel_out_o, mean_o, sample_count_o, minimum_o, maximum_o,
                      overflow_o);
    end
  end

  task send_sample(logic [CH_W-1:0] ch, sample_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(ch, s);
  endtask

  task wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  function sample_t random_sample();
    sample_t s;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0: s = sample_t'(-32768);
          1: s = sample_t'(-1);
          2: s = '0;
          3: s = sample_t'(1);
          default: s = sample_t'(32767);
        endcase
      end
      1: s = sample_t'($urandom_range(100)) - sample_t'(50);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  task run_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_sample(CH_W'($urandom_range(CHANNELS - 1)), random_sample());
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A first sample that is not positive leaves minimum and maximum at zero.
    send_sample(0, sample_t'(-32768));
    send_sample(0, sample_t'(5));
    send_sample(0, sample_t'(32767));
    send_sample(0, sample_t'(1));
    send_sample(1, sample_t'(32767));
    send_sample(1, sample_t'(1));
    send_sample(1, sample_t'(-32768));
    send_sample(1, sample_t'(-32768));
    send_sample(2, sample_t'(0));
    send_sample(2, sample_t'(7));
    send_sample(3, sample_t'(-1));
    send_sample(3, sample_t'(-3));
    send_sample(4, sample_t'(100));
    send_sample(4, sample_t'(50));
    send_sample(4, sample_t'(200));
    send_sample(4, sample_t'(-7));
    send_sample(5, sample_t'(32767));
    send_sample(5, sample_t'(32767));
    send_sample(6, sample_t'(-32768));
    send_sample(6, sample_t'(-32768));
    send_sample(7, sample_t'(1));
    send_sample(7, sample_t'(-1));
    send_sample(7, sample_t'(-2));
    wait_for_results();

    run_random(180, 0, 0);
    run_random(180, 46, 0);
    run_random(180, 0, 46);
    run_random(180, 8, 8);

    // The receiver holds off while the sender keeps offering transactions back to back.
    idle_pct  = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    repeat (15) send_sample(CH_W'($urandom_range(CHANNELS - 1)), random_sample());
    wait_for_results();

    run_random(20, 46, 46);

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
design/pcrs_pkg.sv
design/pcrs_front.sv
design/pcrs_div.sv
design/pcrs_back.sv
design/per_channel_running_stats.sv
tb/sv/per_channel_running_stats_tb.sv
